/* rtl/core/cmq_pkg.sv */
// ----------------------------------------------------------------------------
// cmq_pkg
// Shared types and constants of the CSMA MAC queue controller.
// ----------------------------------------------------------------------------
package cmq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int HANDLE_W   = 32;
   localparam int CAP_W      = 5;
   localparam int MAXB_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd8;
   localparam logic [MAXB_W-1:0] MAXB_RESET = 8'd4;

   // register index, taken from the word address
   localparam logic REG_CAPACITY     = 1'b0;
   localparam logic REG_MAX_BACKOFFS = 1'b1;

   // request codes on req_type
   localparam logic [1:0] REQ_ARRIVAL = 2'd0;
   localparam logic [1:0] REQ_SENSE   = 2'd1;
   localparam logic [1:0] REQ_EXPIRE  = 2'd2;

   typedef enum logic [2:0] {
      ACT_SENSE      = 3'd0,
      ACT_TX         = 3'd1,
      ACT_BACKOFF    = 3'd2,
      ACT_DROP_FULL  = 3'd3,
      ACT_DROP_LIMIT = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_ARRIVE,
      CMD_SENSE_IDLE,
      CMD_SENSE_BUSY,
      CMD_EXPIRE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [HANDLE_W-1:0]  handle;
   } cmd_type;

endpackage

/* rtl/core/cmq_front.sv */
// ----------------------------------------------------------------------------
// cmq_front
// Accepts request beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module cmq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [cmq_pkg::HANDLE_W-1:0]  req_packet_handle,
   input  logic                          req_channel_busy,
   output logic                          cmd_valid,
   output cmq_pkg::cmd_type              cmd,
   input  logic                          cmd_pop
);

   cmq_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   cmq_pkg::cmd_type cls;
   logic             accept;
   logic             push;

   always_comb begin
      cls.handle = req_packet_handle;
      unique case (req_type)
         cmq_pkg::REQ_ARRIVAL: cls.kind = cmq_pkg::CMD_ARRIVE;
         cmq_pkg::REQ_SENSE:   cls.kind = req_channel_busy ? cmq_pkg::CMD_SENSE_BUSY
                                                           : cmq_pkg::CMD_SENSE_IDLE;
         cmq_pkg::REQ_EXPIRE:  cls.kind = cmq_pkg::CMD_EXPIRE;
         default:              cls.kind = cmq_pkg::CMD_NONE;
      endcase
   end

   assign req_stall = (fill_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   // drop unused request codes right here
   assign push      = accept && (cls.kind != cmq_pkg::CMD_NONE);

   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* rtl/core/cmq_back.sv */
// ----------------------------------------------------------------------------
// cmq_back
// Packet FIFO and CSMA sequencing; drives the registered result beat.
// ----------------------------------------------------------------------------
module cmq_back #(
   parameter int QUEUE_DEPTH = cmq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  cmq_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   input  logic [cmq_pkg::CAP_W-1:0]     cfg_capacity,
   input  logic [cmq_pkg::MAXB_W-1:0]    cfg_max_backoffs,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_action,
   output logic [cmq_pkg::HANDLE_W-1:0]  rsp_out_handle,
   output logic                          rsp_last
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > cmq_pkg::CAP_W) ? CNT_W : cmq_pkg::CAP_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_START
   } state_type;

   logic [cmq_pkg::HANDLE_W-1:0] mem [QUEUE_DEPTH];
   logic [cmq_pkg::HANDLE_W-1:0] rd_data_ff;

   state_type                    state_ff, state_in;
   logic [PTR_W-1:0]             rp_ff, rp_in;
   logic [PTR_W-1:0]             wp_ff, wp_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [cmq_pkg::HANDLE_W-1:0] current_ff, current_in;
   logic [cmq_pkg::MAXB_W-1:0]   bc_ff, bc_in;
   logic                         proc_ff, proc_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   cmq_pkg::action_type          rsp_action_ff, rsp_action_in;
   logic [cmq_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         mem_we;
   logic                         out_free;
   logic [CMP_W-1:0]             cap_lim;
   logic [cmq_pkg::MAXB_W-1:0]   bc_sat;
   logic                         queue_empty;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign cap_lim     = (CMP_W'(cfg_capacity) > DEPTH_C) ? DEPTH_C : CMP_W'(cfg_capacity);
   assign bc_sat      = (bc_ff == '1) ? bc_ff : bc_ff + 8'd1;
   assign queue_empty = (count_ff == '0);

   always_comb begin
      state_in      = state_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      count_in      = count_ff;
      current_in    = current_ff;
      bc_in         = bc_ff;
      proc_in       = proc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_action_in = rsp_action_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      cmd_pop       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  cmq_pkg::CMD_ARRIVE: begin
                     if (CMP_W'(count_ff) < cap_lim) begin
                        mem_we   = 1'b1;
                        wp_in    = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
                        count_in = count_ff + CNT_W'(1);
                        if (!proc_ff) begin
                           state_in = ST_FETCH;
                        end
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_action_in = cmq_pkg::ACT_DROP_FULL;
                        rsp_handle_in = cmd.handle;
                        rsp_last_in   = 1'b1;
                     end
                  end
                  cmq_pkg::CMD_SENSE_IDLE: begin
                     if (proc_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_action_in = cmq_pkg::ACT_TX;
                        rsp_handle_in = current_ff;
                        rsp_last_in   = queue_empty;
                        bc_in         = '0;
                        if (queue_empty) begin
                           proc_in = 1'b0;
                        end else begin
                           state_in = ST_FETCH;
                        end
                     end
                  end
                  cmq_pkg::CMD_SENSE_BUSY: begin
                     if (proc_ff) begin
                        rsp_valid_in = 1'b1;
                        if (bc_sat < cfg_max_backoffs) begin
                           rsp_action_in = cmq_pkg::ACT_BACKOFF;
                           rsp_handle_in = '0;
                           rsp_last_in   = 1'b1;
                           bc_in         = bc_sat;
                        end else begin
                           // limit reached: drop and move to the next packet
                           rsp_action_in = cmq_pkg::ACT_DROP_LIMIT;
                           rsp_handle_in = current_ff;
                           rsp_last_in   = queue_empty;
                           bc_in         = '0;
                           if (queue_empty) begin
                              proc_in = 1'b0;
                           end else begin
                              state_in = ST_FETCH;
                           end
                        end
                     end
                  end
                  cmq_pkg::CMD_EXPIRE: begin
                     if (proc_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_action_in = cmq_pkg::ACT_SENSE;
                        rsp_handle_in = '0;
                        rsp_last_in   = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            // head entry lands in rd_data_ff at this edge
            state_in = ST_START;
         end
         ST_START: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = cmq_pkg::ACT_SENSE;
               rsp_handle_in = '0;
               rsp_last_in   = 1'b1;
               current_in    = rd_data_ff;
               rp_in         = (rp_ff == PTR_LAST) ? '0 : rp_ff + PTR_W'(1);
               count_in      = count_ff - CNT_W'(1);
               bc_in         = '0;
               proc_in       = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         count_ff     <= '0;
         bc_ff        <= '0;
         proc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         bc_ff        <= bc_in;
         proc_ff      <= proc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      current_ff    <= current_in;
      rsp_action_ff <= rsp_action_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= cmd.handle;
      end
      rd_data_ff <= mem[rp_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

/* rtl/core/csma_mac_queue_controller.sv */
// Order: a request beat waits in the front queue; its result beat is registered
//   as the back end takes it. The carrier sense request that starts a new packet
//   follows via ST_FETCH and ST_START (one memory read of the packet FIFO plus the
//   load of the current packet). Throughput: 1 request per cycle unless the result
// stalls or a packet starts. Reset (synchronous): packet FIFO empty, controller idle, capacity 8, limit 4.
// ----------------------------------------------------------------------------
// csma_mac_queue_controller
// CSMA transmit-side MAC controller with a bounded packet FIFO.
// ----------------------------------------------------------------------------
module csma_mac_queue_controller #(
   parameter int QUEUE_DEPTH = cmq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_type,
   input  logic [cmq_pkg::HANDLE_W-1:0]    req_packet_handle,
   input  logic                            req_channel_busy,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_action,
   output logic [cmq_pkg::HANDLE_W-1:0]    rsp_out_handle,
   output logic                            rsp_last,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cmq_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [cmq_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [cmq_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   logic [cmq_pkg::CAP_W-1:0]  cap_ff;
   logic [cmq_pkg::MAXB_W-1:0] maxb_ff;
   logic                       csr_write;
   logic                       cmd_valid;
   logic                       cmd_pop;
   cmq_pkg::cmd_type           cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= cmq_pkg::CAP_RESET;
         maxb_ff <= cmq_pkg::MAXB_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            cmq_pkg::REG_CAPACITY:     cap_ff  <= pwdata[cmq_pkg::CAP_W-1:0];
            cmq_pkg::REG_MAX_BACKOFFS: maxb_ff <= pwdata[cmq_pkg::MAXB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         cmq_pkg::REG_CAPACITY:     prdata = cmq_pkg::CSR_DATA_W'(cap_ff);
         cmq_pkg::REG_MAX_BACKOFFS: prdata = cmq_pkg::CSR_DATA_W'(maxb_ff);
         default:                   prdata = '0;
      endcase
   end

   cmq_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_packet_handle (req_packet_handle),
      .req_channel_busy  (req_channel_busy),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   cmq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .cfg_capacity     (cap_ff),
      .cfg_max_backoffs (maxb_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_action       (rsp_action),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_last         (rsp_last)
   );

endmodule

/* rtl/core/cmq_checker.sv */
// ----------------------------------------------------------------------------
// cmq_checker
// Port-level checks of the CSMA MAC queue controller, bound to the top level.
// ----------------------------------------------------------------------------
module cmq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [2:0]                      rsp_action,
   input logic [cmq_pkg::HANDLE_W-1:0]    rsp_out_handle,
   input logic                            rsp_last
);

   // hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_out_handle) && $stable(rsp_last))
   else $error("stalled result beat changed");

   // sense and backoff requests carry no handle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == cmq_pkg::ACT_SENSE || rsp_action == cmq_pkg::ACT_BACKOFF)
         |-> rsp_out_handle == '0)
   else $error("handle on sense or backoff request");

   // backoff and queue-full drop end their request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == cmq_pkg::ACT_BACKOFF || rsp_action == cmq_pkg::ACT_DROP_FULL)
         |-> rsp_last)
   else $error("backoff or full drop not marked last");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
   else $error("result beat right after reset");

endmodule

bind csma_mac_queue_controller cmq_checker u_cmq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_action     (rsp_action),
   .rsp_out_handle (rsp_out_handle),
   .rsp_last       (rsp_last)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CSMA MAC queue controller. A shadow model of the
// packet FIFO and the backoff logic predicts every result beat. Directed
// sequences, capacity and limit extremes, random traffic and a long output
// hold-off are run, with random request gaps and random result stalls.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] REQ_UNUSED    = 2'd3;
   localparam int         SETTLE_CYCLES = 32;
   localparam int         MAX_PRINTS    = 50;

   typedef struct {
      cmq_pkg::action_type act;
      logic [31:0]         hdl;
      logic                last;
   } mac_action_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [1:0]                     req_type;
   logic [cmq_pkg::HANDLE_W-1:0]   req_packet_handle;
   logic                           req_channel_busy;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [2:0]                     rsp_action;
   logic [cmq_pkg::HANDLE_W-1:0]   rsp_out_handle;
   logic                           rsp_last;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [cmq_pkg::CSR_ADDR_W-1:0] paddr;
   logic [cmq_pkg::CSR_DATA_W-1:0] pwdata;
   logic [cmq_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   // shadow state of the controller
   logic [31:0] pkt_fifo [cmq_pkg::QUEUE_DEPTH_DEF];
   logic [3:0]  fifo_rd;
   logic [3:0]  fifo_wr;
   logic [4:0]  fifo_fill;
   logic [31:0] cur_pkt;
   logic [7:0]  retry_cnt;
   logic        mac_active;
   logic [4:0]  cap_reg;
   logic [7:0]  limit_reg;

   mac_action_type mac_actions_due[$];

   int err_count;
   int reqs_sent;
   int beats_checked;
   int reg_writes;
   int hold_left;
   int burst_left;
   bit gaps_on;

   csma_mac_queue_controller #(
      .QUEUE_DEPTH(cmq_pkg::QUEUE_DEPTH_DEF)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_packet_handle(req_packet_handle),
      .req_channel_busy (req_channel_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_action       (rsp_action),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #600_000;
      $display("tb: errors");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      err_count++;
      if (err_count <= MAX_PRINTS)
         $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // ------------------------------------------------------------------------
   // action predictor
   // ------------------------------------------------------------------------
   task automatic push_action(input cmq_pkg::action_type a, input logic [31:0] h);
      mac_action_type item;
      item.act  = a;
      item.hdl  = h;
      item.last = 1'b0;
      mac_actions_due.push_back(item);
   endtask

   // load the head packet and ask for carrier sense, or go idle
   task automatic take_next_packet();
      if (fifo_fill == 0) begin
         mac_active = 1'b0;
      end else begin
         cur_pkt   = pkt_fifo[fifo_rd];
         fifo_rd   = fifo_rd + 4'd1;
         fifo_fill = fifo_fill - 5'd1;
         retry_cnt = 8'd0;
         mac_active = 1'b1;
         push_action(cmq_pkg::ACT_SENSE, 32'h0);
      end
   endtask

   task automatic predict_actions(input logic [1:0] kind, input logic [31:0] hdl,
                                  input logic chan_busy);
      int             n0;
      logic [4:0]     room;
      mac_action_type tail;
      n0   = mac_actions_due.size();
      room = (cap_reg > 5'd16) ? 5'd16 : cap_reg;
      case (kind)
         cmq_pkg::REQ_ARRIVAL: begin
            if (fifo_fill < room) begin
               pkt_fifo[fifo_wr] = hdl;
               fifo_wr   = fifo_wr + 4'd1;
               fifo_fill = fifo_fill + 5'd1;
               if (!mac_active)
                  take_next_packet();
            end else begin
               push_action(cmq_pkg::ACT_DROP_FULL, hdl);
            end
         end
         cmq_pkg::REQ_SENSE: begin
            if (mac_active && !chan_busy) begin
               push_action(cmq_pkg::ACT_TX, cur_pkt);
               retry_cnt = 8'd0;
               take_next_packet();
            end else if (mac_active) begin
               if (retry_cnt != 8'd255)
                  retry_cnt = retry_cnt + 8'd1;
               if (retry_cnt < limit_reg) begin
                  push_action(cmq_pkg::ACT_BACKOFF, 32'h0);
               end else begin
                  push_action(cmq_pkg::ACT_DROP_LIMIT, cur_pkt);
                  retry_cnt = 8'd0;
                  take_next_packet();
               end
            end
         end
         cmq_pkg::REQ_EXPIRE: begin
            if (mac_active)
               push_action(cmq_pkg::ACT_SENSE, 32'h0);
         end
         default: ;
      endcase
      // flag the final beat of this request
      if (mac_actions_due.size() > n0) begin
         tail = mac_actions_due.pop_back();
         tail.last = 1'b1;
         mac_actions_due.push_back(tail);
      end
   endtask

   // ------------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_beat
      mac_action_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (mac_actions_due.size() == 0) begin
            report_mismatch($sformatf("unexpected beat action %0d handle %h last %b",
                                      rsp_action, rsp_out_handle, rsp_last));
         end else begin
            want = mac_actions_due.pop_front();
            if (rsp_action !== want.act || rsp_out_handle !== want.hdl ||
                rsp_last !== want.last)
               report_mismatch($sformatf(
                  "beat got action %0d handle %h last %b, want %0d %h %b",
                  rsp_action, rsp_out_handle, rsp_last, want.act, want.hdl, want.last));
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver stall pattern; a requested hold-off overrides it
   // ------------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int      stall_mode;
      int      stretch_left;
      int unsigned stall_tick;
      stall_mode   = 0;
      stretch_left = 0;
      stall_tick   = 0;
      rsp_stall    = 1'b0;
      forever begin
         @(negedge clock);
         stall_tick++;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (stretch_left == 0) begin
               stall_mode   = $urandom_range(0, 3);
               stretch_left = $urandom_range(16, 160);
            end else begin
               stretch_left--;
            end
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               2: rsp_stall <= (stall_tick % 5) < 2;
               default: rsp_stall <= $urandom_range(0, 9) < 7;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // request channel and register port
   // ------------------------------------------------------------------------
   task automatic send_req(input logic [1:0] kind, input logic [31:0] hdl,
                           input logic chan_busy);
      int gap;
      gap = 0;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_packet_handle <= hdl;
      req_channel_busy  <= chan_busy;
      do @(posedge clock); while (req_stall);
      predict_actions(kind, hdl, chan_busy);
      reqs_sent++;
   endtask

   // drop valid, let every due beat arrive, then cover the pipeline latency
   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (mac_actions_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write one register, then read it back
   task automatic write_reg(input logic idx, input logic [31:0] val);
      logic [31:0] want;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == cmq_pkg::REG_CAPACITY) begin
         cap_reg = val[4:0];
         want    = {27'd0, val[4:0]};
      end else begin
         limit_reg = val[7:0];
         want      = {24'd0, val[7:0]};
      end
      reg_writes++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want)
         report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, want));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_mac_config(input logic [4:0] room, input logic [7:0] lim);
      settle();
      write_reg(cmq_pkg::REG_CAPACITY, {27'd0, room});
      write_reg(cmq_pkg::REG_MAX_BACKOFFS, {24'd0, lim});
   endtask

   task automatic send_random_item(input int busy_pct);
      int          roll;
      logic [1:0]  kind;
      logic [31:0] hdl;
      logic        chan;
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 19))
         0:       hdl = 32'h0;
         1:       hdl = 32'hffff_ffff;
         default: hdl = $urandom;
      endcase
      chan = $urandom_range(0, 99) < busy_pct;
      if (!mac_active)
         kind = (roll < 75) ? cmq_pkg::REQ_ARRIVAL : 2'($urandom_range(1, 3));
      else if (roll < 25)
         kind = cmq_pkg::REQ_ARRIVAL;
      else if (roll < 75)
         kind = cmq_pkg::REQ_SENSE;
      else if (roll < 93)
         kind = cmq_pkg::REQ_EXPIRE;
      else
         kind = REQ_UNUSED;
      send_req(kind, hdl, chan);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      int i;
      // idle controller ignores everything but arrivals
      send_req(cmq_pkg::REQ_SENSE, 32'h0, 1'b1);
      send_req(cmq_pkg::REQ_SENSE, 32'h0, 1'b0);
      send_req(cmq_pkg::REQ_EXPIRE, 32'h0, 1'b0);
      send_req(REQ_UNUSED, 32'hffff_ffff, 1'b1);
      send_req(cmq_pkg::REQ_ARRIVAL, 32'hffff_ffff, 1'b0);
      send_req(cmq_pkg::REQ_ARRIVAL, 32'h0000_0000, 1'b1);
      send_req(cmq_pkg::REQ_ARRIVAL, 32'h5a5a_a5a5, 1'b0);
      send_req(cmq_pkg::REQ_SENSE, 32'h0, 1'b1);
      send_req(cmq_pkg::REQ_EXPIRE, 32'h0, 1'b0);
      // busy until the limit, drop and move on
      for (i = 0; i < 3; i++)
         send_req(cmq_pkg::REQ_SENSE, 32'h0, 1'b1);
      send_req(cmq_pkg::REQ_SENSE, 32'h0, 1'b0);
      send_req(REQ_UNUSED, 32'h1234_5678, 1'b0);
      send_req(cmq_pkg::REQ_SENSE, 32'h0, 1'b0);
      send_req(cmq_pkg::REQ_EXPIRE, 32'h0, 1'b1);
      // overfill the queue at reset capacity
      for (i = 0; i < 10; i++)
         send_req(cmq_pkg::REQ_ARRIVAL, 32'h8000_0000 | i, 1'b0);
   endtask

   task automatic test_limits();
      int i;
      // capacity zero, limit zero: drain the queue through drops, ending empty
      set_mac_config(5'd0, 8'd0);
      for (i = 0; i < 3; i++)
         send_req(cmq_pkg::REQ_ARRIVAL, $urandom, 1'b0);
      for (i = 0; i < 10; i++)
         send_req(cmq_pkg::REQ_SENSE, $urandom, 1'b1);
      send_req(cmq_pkg::REQ_EXPIRE, 32'h0, 1'b0);
      // capacity above depth, highest limit
      set_mac_config(5'd31, 8'd255);
      for (i = 0; i < 20; i++)
         send_req(cmq_pkg::REQ_ARRIVAL, $urandom, 1'b0);
      for (i = 0; i < 255; i++)
         send_req(cmq_pkg::REQ_SENSE, $urandom, 1'b1);
      send_req(cmq_pkg::REQ_EXPIRE, 32'h0, 1'b0);
      // capacity lowered under the fill: drop until it drains below
      set_mac_config(5'd3, 8'd255);
      for (i = 0; i < 3; i++)
         send_req(cmq_pkg::REQ_ARRIVAL, $urandom, 1'b0);
      for (i = 0; i < 13; i++)
         send_req(cmq_pkg::REQ_SENSE, 32'h0, 1'b0);
      for (i = 0; i < 3; i++)
         send_req(cmq_pkg::REQ_ARRIVAL, $urandom, 1'b0);
      set_mac_config(5'd1, 8'd1);
      for (i = 0; i < 8; i++)
         send_req(cmq_pkg::REQ_SENSE, $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_random();
      int          phase;
      int          i;
      int          busy_pct;
      logic [4:0]  room;
      logic [7:0]  lim;
      for (phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 5))
            0:       room = 5'd0;
            1:       room = 5'd16;
            2:       room = 5'($urandom_range(17, 31));
            default: room = 5'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 5))
            0:       lim = 8'd0;
            1:       lim = 8'd255;
            2:       lim = 8'($urandom_range(0, 255));
            default: lim = 8'($urandom_range(1, 6));
         endcase
         busy_pct = $urandom_range(0, 100);
         gaps_on  = (phase % 3) != 2;
         set_mac_config(room, lim);
         for (i = 0; i < 150; i++)
            send_random_item(busy_pct);
      end
      gaps_on = 1'b1;
   endtask

   // hold the result side so the block backs up into its input
   task automatic test_pressure();
      int i;
      set_mac_config(5'd16, 8'd3);
      gaps_on   = 1'b0;
      hold_left = 400;
      for (i = 0; i < 120; i++)
         send_random_item(50);
      gaps_on = 1'b1;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_type          = cmq_pkg::REQ_ARRIVAL;
      req_packet_handle = '0;
      req_channel_busy  = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      err_count         = 0;
      reqs_sent         = 0;
      beats_checked     = 0;
      reg_writes        = 0;
      hold_left         = 0;
      burst_left        = 0;
      gaps_on           = 1'b1;
      foreach (pkt_fifo[i])
         pkt_fifo[i] = 32'h0;
      fifo_rd    = 4'd0;
      fifo_wr    = 4'd0;
      fifo_fill  = 5'd0;
      cur_pkt    = 32'h0;
      retry_cnt  = 8'd0;
      mac_active = 1'b0;
      cap_reg    = cmq_pkg::CAP_RESET;
      limit_reg  = cmq_pkg::MAXB_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_directed();
      test_limits();
      test_random();
      test_pressure();
      settle();

      $display("summary: %0d request beats, %0d result beats checked, %0d register writes",
               reqs_sent, beats_checked, reg_writes);
      $display("summary: capacity 0..31, backoff limit 0..255, idle noise, output hold-off");
      if (err_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
